>>> rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// assertion shorthands shared by the bucket table rtl
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold at every clock edge out of reset
`define SSBU_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// implication into the next cycle
`define SSBU_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

>>> rtl/ssbu_pkg.sv
// ----------------------------------------------------------------------------
// ssbu_pkg
// types, codes and the bucket update function of the shared bucket table
// ----------------------------------------------------------------------------
package ssbu_pkg;

  // table size is a power of two
  localparam int TABLE_SIZE = 1024;
  localparam int MAX_PROBES = 8;
  localparam int NUM_SLOTS  = 8;

  localparam int IDX_W  = $clog2(TABLE_SIZE);
  localparam int PRB_W  = $clog2(MAX_PROBES) + 1;
  localparam int HOME_W = 10;
  localparam int SLOT_W = 3;
  localparam int KIND_W = 3;
  localparam int TYPE_W = 4;
  localparam int CNT_W  = 32;
  localparam int KLO_W  = 64;
  localparam int KHI_W  = 40;
  localparam int STAT_W = 3;
  localparam int CFG_W  = 32;

  localparam int IN_DATA_W  = 120;
  localparam int OUT_DATA_W = 200;

  localparam logic [HOME_W-1:0] HOME_MASK =
    HOME_W'((TABLE_SIZE < 1024) ? (TABLE_SIZE - 1) : 1023);

  localparam logic [CNT_W-1:0] U32_MAX = 32'hFFFF_FFFF;
  localparam logic [CNT_W-1:0] S32_MAX = 32'h7FFF_FFFF;
  localparam logic [CNT_W-1:0] S32_MIN = 32'h8000_0000;

  // result status codes
  localparam logic [STAT_W-1:0] ST_HIT    = 3'd0;
  localparam logic [STAT_W-1:0] ST_NEW    = 3'd1;
  localparam logic [STAT_W-1:0] ST_FULL   = 3'd2;
  localparam logic [STAT_W-1:0] ST_UNUSED = 3'd3;
  localparam logic [STAT_W-1:0] ST_READ   = 3'd4;

  // slot kinds as held in the slot type register
  localparam logic [TYPE_W-1:0] KIND_NONE  = 4'd0;
  localparam logic [TYPE_W-1:0] KIND_CM    = 4'd1;
  localparam logic [TYPE_W-1:0] KIND_CS    = 4'd2;
  localparam logic [TYPE_W-1:0] KIND_MV_HI = 4'd5;

  localparam logic FUNC_READ = 1'b1;

  typedef struct packed {
    logic              used;
    logic [KIND_W-1:0] kind;
    logic [SLOT_W-1:0] slot;
    logic [HOME_W-1:0] home;
    logic [CNT_W-1:0]  counter;
    logic [KLO_W-1:0]  cand_lo;
    logic [KHI_W-1:0]  cand_hi;
    logic [CNT_W-1:0]  cand_cnt;
  } bucket_t;

  localparam int BUCKET_W = $bits(bucket_t);

  function automatic logic [IDX_W-1:0] home_to_idx(logic [HOME_W-1:0] h);
    return IDX_W'({22'd0, h});
  endfunction

  function automatic logic [HOME_W-1:0] idx_to_home(logic [IDX_W-1:0] i);
    return HOME_W'({16'd0, i});
  endfunction

  // one update of a bucket for the slot's current kind
  function automatic bucket_t bucket_update(bucket_t b, logic [TYPE_W-1:0] kind,
                                            logic neg, logic [KLO_W-1:0] klo,
                                            logic [KHI_W-1:0] khi);
    bucket_t r;
    logic    dn;
    logic    sat;
    logic    nonpos;
    logic    key_eq;
    r      = b;
    dn     = (kind == KIND_CS) && neg;
    if (kind == KIND_CS) begin
      sat = neg ? (b.counter == S32_MIN) : (b.counter == S32_MAX);
    end else begin
      sat = (b.counter == U32_MAX);
    end
    if (!sat) begin
      r.counter = dn ? (b.counter - 32'd1) : (b.counter + 32'd1);
    end
    nonpos = b.cand_cnt[CNT_W-1] || (b.cand_cnt == '0);
    key_eq = (b.cand_lo == klo) && (b.cand_hi == khi);
    if (kind != KIND_CM && kind != KIND_CS) begin
      if (nonpos || (!key_eq && b.cand_cnt == 32'd1)) begin
        r.cand_lo  = klo;
        r.cand_hi  = khi;
        r.cand_cnt = 32'd1;
      end else if (key_eq) begin
        if (b.cand_cnt != S32_MAX) begin
          r.cand_cnt = b.cand_cnt + 32'd1;
        end
      end else begin
        r.cand_cnt = b.cand_cnt - 32'd1;
      end
    end
    return r;
  endfunction

endpackage

>>> rtl/ssbu_ram.sv
// ----------------------------------------------------------------------------
// ssbu_ram
// simple dual port ram, one write and one registered read per cycle
// ----------------------------------------------------------------------------
module ssbu_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

>>> rtl/shared_sketch_bucket_update.sv
// ----------------------------------------------------------------------------
// shared_sketch_bucket_update
// bucket table shared by several sketch slots, linear probing on update
// ----------------------------------------------------------------------------
// channel | dir | handshake              | payload
// in_     | in  | in_tvalid / in_tready   | in_tuser func, in_tdata update or read
// out_    | out | out_tvalid / out_tready | out_tuser status, out_tdata bucket
// cfg_    | in  | cfg_wen                 | cfg_wdata slot types, 4 bits per slot
//
// a read passes S_LOOKUP and S_EMIT; an update probes up to MAX_PROBES buckets
//   in S_LOOKUP, one probe per cycle through the single registered read port
// a rejected slot goes straight to S_EMIT; one item is in flight at a time
// reset: a clearing pass zeroes all TABLE_SIZE (1024) entries of the table,
//   in_tready stays low during it
// a waiting result sits in the output register while the next beat is taken
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module shared_sketch_bucket_update
  import ssbu_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_wen,
  input  logic [CFG_W-1:0]      cfg_wdata,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // slot[2:0] home_index[12:3] sign_negative[13] flow_key_low[77:14]
  // flow_key_high[117:78], zero fill above
  input  logic [IN_DATA_W-1:0]  in_tdata,
  // func[0]
  input  logic                  in_tuser,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // bucket_index[9:0] bucket_used[10] bucket_kind[13:11] bucket_slot[16:14]
  // bucket_home[26:17] bucket_counter[58:27] candidate_low[122:59]
  // candidate_high[162:123] candidate_count[194:163], zero fill above
  output logic [OUT_DATA_W-1:0] out_tdata,
  // status[2:0]
  output logic [STAT_W-1:0]     out_tuser
);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_LOOKUP,
    S_UPDATE,
    S_EMIT
  } state_t;

  state_t                  state_r;
  logic [CFG_W-1:0]        slot_types_r;
  logic [IDX_W-1:0]        clr_r;
  logic                    func_r;
  logic [SLOT_W-1:0]       slot_r;
  logic [HOME_W-1:0]       home_r;
  logic                    neg_r;
  logic [KLO_W-1:0]        klo_r;
  logic [KHI_W-1:0]        khi_r;
  logic [TYPE_W-1:0]       kind_r;
  logic [IDX_W-1:0]        addr_r;
  logic [PRB_W-1:0]        probe_r;
  logic [STAT_W-1:0]       status_r;
  logic [HOME_W-1:0]       res_idx_r;
  bucket_t                 rec_r;
  logic                    out_tvalid_r;
  logic [OUT_DATA_W-1:0]   out_tdata_r;
  logic [STAT_W-1:0]       out_tuser_r;

  logic [SLOT_W-1:0]       in_slot;
  logic [HOME_W-1:0]       in_home;
  logic [TYPE_W-1:0]       in_kind;
  logic                    in_bad;
  logic                    in_fire;
  logic                    emit_go;
  logic [IDX_W-1:0]        next_addr;
  logic                    ram_we;
  logic [IDX_W-1:0]        ram_waddr;
  logic [IDX_W-1:0]        ram_raddr;
  logic [BUCKET_W-1:0]     ram_wdata;
  logic [BUCKET_W-1:0]     ram_rdata;
  bucket_t                 rd_bkt;
  bucket_t                 upd_bkt;
  bucket_t                 claim_bkt;

  assign in_slot = in_tdata[2:0];
  assign in_home = in_tdata[12:3] & HOME_MASK;
  assign in_kind = slot_types_r[{in_slot, 2'b00} +: TYPE_W];
  assign in_bad  = ({1'b0, in_slot} >= 4'(NUM_SLOTS)) || (in_kind == KIND_NONE) ||
                   (in_kind > KIND_MV_HI);
  assign in_fire = in_tvalid && in_tready;
  assign emit_go = (state_r == S_EMIT) && (!out_tvalid_r || out_tready);

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;

  assign next_addr = (addr_r == IDX_W'(TABLE_SIZE - 1)) ? '0 : (addr_r + 1'b1);
  assign rd_bkt    = bucket_t'(ram_rdata);
  assign upd_bkt   = bucket_update(rec_r, kind_r, neg_r, klo_r, khi_r);

  always_comb begin
    claim_bkt      = '0;
    claim_bkt.used = 1'b1;
    claim_bkt.kind = KIND_W'(kind_r);
    claim_bkt.slot = slot_r;
    claim_bkt.home = home_r;
  end

  assign ram_we    = (state_r == S_CLEAR) || (state_r == S_UPDATE);
  assign ram_waddr = (state_r == S_CLEAR) ? clr_r : addr_r;
  assign ram_wdata = (state_r == S_CLEAR) ? '0 : BUCKET_W'(upd_bkt);
  assign ram_raddr = (state_r == S_IDLE) ? home_to_idx(in_home) : next_addr;

  ssbu_ram #(
    .WIDTH (BUCKET_W),
    .DEPTH (TABLE_SIZE)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_CLEAR;
      slot_types_r <= '0;
      clr_r        <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      if (cfg_wen) begin
        slot_types_r <= cfg_wdata;
      end
      if (emit_go) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
      case (state_r)
        S_CLEAR: begin
          clr_r <= clr_r + 1'b1;
          if (clr_r == IDX_W'(TABLE_SIZE - 1)) begin
            state_r <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_fire) begin
            func_r    <= in_tuser;
            slot_r    <= in_slot;
            home_r    <= in_home;
            neg_r     <= in_tdata[13];
            klo_r     <= in_tdata[77:14];
            khi_r     <= in_tdata[117:78];
            kind_r    <= in_kind;
            addr_r    <= home_to_idx(in_home);
            probe_r   <= '0;
            res_idx_r <= in_home;
            if (in_tuser != FUNC_READ && in_bad) begin
              status_r <= ST_UNUSED;
              rec_r    <= '0;
              state_r  <= S_EMIT;
            end else begin
              state_r  <= S_LOOKUP;
            end
          end
        end
        S_LOOKUP: begin
          // table data for addr_r is on the read port this cycle
          if (func_r == FUNC_READ) begin
            rec_r    <= rd_bkt;
            status_r <= ST_READ;
            state_r  <= S_EMIT;
          end else if (!rd_bkt.used) begin
            rec_r     <= claim_bkt;
            status_r  <= ST_NEW;
            res_idx_r <= idx_to_home(addr_r);
            state_r   <= S_UPDATE;
          end else if (rd_bkt.slot == slot_r && rd_bkt.home == home_r) begin
            rec_r     <= rd_bkt;
            status_r  <= ST_HIT;
            res_idx_r <= idx_to_home(addr_r);
            state_r   <= S_UPDATE;
          end else if (probe_r == PRB_W'(MAX_PROBES - 1)) begin
            rec_r    <= '0;
            status_r <= ST_FULL;
            state_r  <= S_EMIT;
          end else begin
            probe_r <= probe_r + 1'b1;
            addr_r  <= next_addr;
          end
        end
        S_UPDATE: begin
          rec_r   <= upd_bkt;
          state_r <= S_EMIT;
        end
        S_EMIT: begin
          if (emit_go) begin
            out_tuser_r  <= status_r;
            out_tdata_r  <= {5'd0, rec_r.cand_cnt, rec_r.cand_hi, rec_r.cand_lo,
                             rec_r.counter, rec_r.home, rec_r.slot, rec_r.kind,
                             rec_r.used, res_idx_r};
            state_r      <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  `SSBU_ASSERT(a_no_write_when_ready, !in_tready || !ram_we, "table written while ready")
  `SSBU_ASSERT(a_probe_bound, (state_r != S_LOOKUP) || (probe_r <= PRB_W'(MAX_PROBES - 1)), "probe count past limit")
  `SSBU_ASSERT_NXT(a_busy_after_accept, in_fire, state_r != S_IDLE, "ready again right after a beat")
  `SSBU_ASSERT(a_result_from_emit, !$rose(out_tvalid_r) || $past(state_r == S_EMIT), "result without emit")
  `SSBU_ASSERT(a_claim_marks_used, !(state_r == S_UPDATE) || rec_r.used, "update of a bucket not marked used")

endmodule
